[hw/rtl/wavelength_to_rgb_color_macros.svh]
// Assertion helpers used by the checker module.
// Each macro expects signals named clk and rst in scope.
`ifndef WAVELENGTH_TO_RGB_COLOR_MACROS_SVH
`define WAVELENGTH_TO_RGB_COLOR_MACROS_SVH

// Same-cycle implication, held off while in reset.
`define WTRGB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while in reset.
`define WTRGB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/wtrgb_pkg.sv]
`timescale 1ns / 1ps

package wtrgb_pkg;

  // UQ1.15 full scale and the dim out-of-band level (0.3)
  localparam logic [15:0] ONE_Q = 16'd32768;
  localparam logic [15:0] DIM_Q = 16'd9830;

  // Band and segment borders in 1/64 nm
  localparam logic [15:0] W_380 = 16'd24320;
  localparam logic [15:0] W_420 = 16'd26880;
  localparam logic [15:0] W_440 = 16'd28160;
  localparam logic [15:0] W_490 = 16'd31360;
  localparam logic [15:0] W_510 = 16'd32640;
  localparam logic [15:0] W_580 = 16'd37120;
  localparam logic [15:0] W_645 = 16'd41280;
  localparam logic [15:0] W_700 = 16'd44800;
  localparam logic [15:0] W_750 = 16'd48000;

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  // Constant divide: q = (n * ceil(2^RECIP_SH / L)) >> RECIP_SH, exact for n < 2^22, L < 128
  localparam int NUM_W    = 22;
  localparam int RECIP_W  = 25;
  localparam int PROD_W   = NUM_W + RECIP_W;
  localparam int RECIP_SH = 29;

  typedef enum logic [2:0] {
    CLS_BELOW,  // under 380 nm
    CLS_ABOVE,  // over 750 nm
    CLS_VB,     // violet to blue
    CLS_BC,     // blue to cyan
    CLS_CG,     // cyan to green
    CLS_GY,     // green to yellow
    CLS_YO,     // yellow to orange
    CLS_OR      // orange to red
  } cls_t;

  typedef enum logic [1:0] {
    RAMP_NONE,
    RAMP_LOW,
    RAMP_HIGH
  } ramp_t;

  typedef struct packed {
    cls_t              cls;
    ramp_t             ramp;
    logic [NUM_W-1:0]  n_ch;
    logic [NUM_W-1:0]  n_f;
    logic [15:0]       inten;
  } work_t;

  // Reciprocal of the segment length in nm
  function automatic logic [RECIP_W-1:0] seg_recip(cls_t cls);
    case (cls)
      CLS_VB:  return 25'd8947849;   // 60
      CLS_BC:  return 25'd10737419;  // 50
      CLS_CG:  return 25'd26843546;  // 20
      CLS_GY:  return 25'd7669585;   // 70
      CLS_YO:  return 25'd8259553;   // 65
      CLS_OR:  return 25'd5113057;   // 105
      default: return '0;
    endcase
  endfunction

  // Reciprocal of the ramp divisor
  function automatic logic [RECIP_W-1:0] ramp_recip(ramp_t ramp);
    case (ramp)
      RAMP_LOW:  return 25'd21474837;  // 25
      RAMP_HIGH: return 25'd4294968;   // 125
      default:   return '0;
    endcase
  endfunction

  // Quotient out of the product, clamped to full scale
  function automatic logic [15:0] quot(logic [PROD_W-1:0] p);
    logic [PROD_W-RECIP_SH-1:0] q;
    q = p[PROD_W-1:RECIP_SH];
    return (q > (PROD_W - RECIP_SH)'(ONE_Q)) ? ONE_Q : q[15:0];
  endfunction

  // UQ1.15 product rounded to nearest, clamped to full scale
  function automatic logic [15:0] qround(logic [31:0] p);
    logic [31:0] s;
    s = p + 32'd16384;
    return (s[31:15] > 17'(ONE_Q)) ? ONE_Q : s[30:15];
  endfunction

endpackage

[hw/rtl/wavelength_to_rgb_color.sv]
`timescale 1ns / 1ps

// Wavelength to RGB colour. Each input word carries a wavelength in nm with
// 6 fraction bits and a UQ1.15 intensity (above 1.0 counts as 1.0); each
// output word carries red, green and blue levels in UQ1.15, 0..32768. The
// visible band 380..750 nm is covered by six linear segments, faded towards
// 0.3 below 420 nm and above 700 nm; below the band the colour is a dim
// violet, above it a dim red. One word is accepted per cycle and one result
// leaves per cycle while the output is taken. A word passes the classifying
// front register, the four-word queue, the back pipeline's reciprocal
// multiply, edge factor multiply and intensity multiply stages, and then
// the output register. Output back-pressure freezes only the back pipeline;
// the queue lets the front keep taking words until it fills.
module wavelength_to_rgb_color
  import wtrgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] wavelength_q, [31:16] ray_intensity
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // [15:0] red_level, [31:16] green_level,
                                 // [47:32] blue_level
);

  logic  push;
  logic  pop;
  logic  full;
  logic  empty;
  work_t push_data;
  work_t pop_data;

  // classify and build the divide numerators
  wtrgb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  // decouples the front from output stalls
  wtrgb_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  // divide by segment length, edge fade, intensity, output register
  wtrgb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop      (pop),
    .pop_data (pop_data),
    .empty    (empty),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

[hw/rtl/wtrgb_front.sv]
`timescale 1ns / 1ps

module wtrgb_front
  import wtrgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,
  output logic        push,
  output work_t       push_data,
  input  logic        full
);

  logic        valid;
  work_t       item;
  work_t       item_next;
  logic [15:0] w;
  logic [15:0] i;
  logic [15:0] x;
  logic [15:0] dl;
  logic [15:0] dh;
  logic [14:0] y_lo;
  logic [14:0] y_hi;
  logic        in_band;
  logic        take;

  assign w        = s_tdata[15:0];
  assign i        = s_tdata[31:16];
  assign s_tready = !valid || !full;
  assign take     = s_tvalid && s_tready;
  assign push     = valid && !full;
  assign push_data = item;

  assign in_band = (w >= W_380) && (w <= W_750);
  assign dl      = w - W_380;
  assign dh      = W_750 - w;
  assign y_lo    = 15'd7680 + dl[14:0] * 15'd7;
  assign y_hi    = 15'd9600 + dh[14:0] * 15'd7;

  // segment, numerator for the varying channel, edge ramp numerator
  always_comb begin
    item_next.inten = (i > ONE_Q) ? ONE_Q : i;
    item_next.n_ch  = '0;
    x               = '0;
    if (w < W_380) begin
      item_next.cls = CLS_BELOW;
    end else if (w > W_750) begin
      item_next.cls = CLS_ABOVE;
    end else if (w < W_440) begin
      item_next.cls  = CLS_VB;
      x              = W_440 - w;
      item_next.n_ch = {x[13:0], 8'd0} + 22'd30;
    end else if (w < W_490) begin
      item_next.cls  = CLS_BC;
      x              = w - W_440;
      item_next.n_ch = {x[12:0], 9'd0} + 22'd25;
    end else if (w < W_510) begin
      item_next.cls  = CLS_CG;
      x              = W_510 - w;
      item_next.n_ch = {x[12:0], 9'd0} + 22'd10;
    end else if (w < W_580) begin
      item_next.cls  = CLS_GY;
      x              = w - W_510;
      item_next.n_ch = {x[12:0], 9'd0} + 22'd35;
    end else if (w < W_645) begin
      item_next.cls  = CLS_YO;
      x              = 16'd45440 - w;  // 2L - d
      item_next.n_ch = {x[13:0], 8'd0} + 22'd32;
    end else begin
      item_next.cls  = CLS_OR;
      x              = W_750 - w;
      item_next.n_ch = {x[13:0], 8'd0} + 22'd52;
    end

    if (in_band && (w < W_420)) begin
      item_next.ramp = RAMP_LOW;
      item_next.n_f  = {2'd0, y_lo, 5'd0} + 22'd12;
    end else if (in_band && (w > W_700)) begin
      item_next.ramp = RAMP_HIGH;
      item_next.n_f  = {y_hi, 7'd0} + 22'd62;
    end else begin
      item_next.ramp = RAMP_NONE;
      item_next.n_f  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (push) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item <= item_next;
    end
  end

endmodule

[hw/rtl/wtrgb_fifo.sv]
`timescale 1ns / 1ps

module wtrgb_fifo
  import wtrgb_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t push_data,
  output logic  full,
  input  logic  pop,
  output work_t pop_data,
  output logic  empty
);

  work_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;

  assign full     = (count == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

[hw/rtl/wtrgb_back.sv]
`timescale 1ns / 1ps

module wtrgb_back
  import wtrgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  output logic        pop,
  input  work_t       pop_data,
  input  logic        empty,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata
);

  logic              adv;
  logic [3:0]        v;

  // stage 1: reciprocal products
  logic [PROD_W-1:0] prod_ch;
  logic [PROD_W-1:0] prod_f;
  cls_t              cls1;
  ramp_t             ramp1;
  logic [15:0]       inten1;

  // stage 2: channel times edge factor
  logic [15:0]       q_ch;
  logic [15:0]       f;
  logic [15:0]       ch [3];
  logic [31:0]       p1 [3];
  logic [15:0]       inten2;

  // stage 3: times intensity
  logic [31:0]       p2 [3];

  assign adv      = !v[3] || m_tready;
  assign pop      = adv && !empty;
  assign m_tvalid = v[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[2:0], !empty};
    end
  end

  assign q_ch = quot(prod_ch);
  assign f    = (ramp1 == RAMP_NONE) ? ONE_Q : quot(prod_f);

  always_comb begin
    ch[0] = '0;
    ch[1] = '0;
    ch[2] = '0;
    case (cls1)
      CLS_BELOW: begin
        ch[0] = DIM_Q;
        ch[2] = DIM_Q;
      end
      CLS_ABOVE: begin
        ch[0] = DIM_Q;
      end
      CLS_VB: begin
        ch[0] = q_ch;
        ch[2] = ONE_Q;
      end
      CLS_BC: begin
        ch[1] = q_ch;
        ch[2] = ONE_Q;
      end
      CLS_CG: begin
        ch[1] = ONE_Q;
        ch[2] = q_ch;
      end
      CLS_GY: begin
        ch[0] = q_ch;
        ch[1] = ONE_Q;
      end
      CLS_YO, CLS_OR: begin
        ch[0] = ONE_Q;
        ch[1] = q_ch;
      end
      default: begin
        ch[0] = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_ch <= pop_data.n_ch * seg_recip(pop_data.cls);
      prod_f  <= pop_data.n_f * ramp_recip(pop_data.ramp);
      cls1    <= pop_data.cls;
      ramp1   <= pop_data.ramp;
      inten1  <= pop_data.inten;

      inten2  <= inten1;
      for (int k = 0; k < 3; k++) begin
        p1[k] <= ch[k] * f;
        p2[k] <= qround(p1[k]) * inten2;
      end

      m_tdata <= {qround(p2[2]), qround(p2[1]), qround(p2[0])};
    end
  end

endmodule

[hw/rtl/wtrgb_checker.sv]
`timescale 1ns / 1ps
`include "wavelength_to_rgb_color_macros.svh"

module wtrgb_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  `WTRGB_ASSERT_NOW(a_idle_after_rst, $past(rst), !m_tvalid && s_tready, "not idle after reset")

  `WTRGB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed while stalled")

  `WTRGB_ASSERT_NOW(a_full_scale, m_tvalid, (m_tdata[15:0] <= 16'd32768) && (m_tdata[31:16] <= 16'd32768) && (m_tdata[47:32] <= 16'd32768), "level above full scale")

  `WTRGB_ASSERT_NOW(a_violet_no_green, m_tvalid && (m_tdata[15:0] != 16'd0) && (m_tdata[47:32] != 16'd0), m_tdata[31:16] == 16'd0, "green with red and blue")

endmodule

bind wavelength_to_rgb_color wtrgb_checker u_chk (.*);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

// Checks the wavelength to RGB colour block against a behavioural predictor.
// Every accepted input word gets a predicted colour queued behind it; each
// output word is checked field by field against the oldest prediction.
module testbench;
  import wtrgb_pkg::*;

  localparam int HALF_PERIOD  = 1;
  localparam int RESET_CYCLES = 4;
  localparam int QUIET_LIMIT  = 2000;  // cycles with no word moving on either side
  localparam int HOLD_CYCLES  = 300;   // long output hold-off for the back-pressure test
  localparam int DRAIN_CYCLES = 20;    // extra wait after the last test
  localparam int RANDOM_WORDS = 300;
  localparam int BURST_WORDS  = 40;
  localparam int STREAM_WORDS = 60;

  // Segment borders, used to aim random wavelengths near each one
  localparam logic [15:0] BORDERS [9] = '{W_380, W_420, W_440, W_490, W_510,
                                          W_580, W_645, W_700, W_750};

  typedef struct packed {
    logic [15:0] blue;
    logic [15:0] green;
    logic [15:0] red;
  } rgb_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [15:0] wavelength_q, [31:16] ray_intensity
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // [15:0] red_level, [31:16] green_level, [47:32] blue_level

  rgb_t colour_due[$];    // predicted colours, oldest first

  int  words_sent;
  int  colours_checked;
  int  mismatches;
  int  long_holds;
  bit  send_idle;         // sender inserts random gaps
  bit  recv_idle;         // receiver inserts random stalls
  bit  hold_req;          // ask the receiver for one long hold-off

  wavelength_to_rgb_color u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------------
  // Colour predictor. Wide unsigned arithmetic throughout, rounding to
  // nearest with ties up.
  // ---------------------------------------------------------------------------
  function automatic longint unsigned div_round(longint unsigned num,
                                                longint unsigned den);
    return (num + den / 2) / den;
  endfunction

  // UQ1.15 product, rounded, saturating at full scale
  function automatic longint unsigned uq_mul(longint unsigned a, longint unsigned b);
    longint unsigned p;
    p = (a * b + 16384) >> 15;
    return (p > ONE_Q) ? ONE_Q : p;
  endfunction

  function automatic rgb_t predict_colour(logic [15:0] wl, logic [15:0] inten);
    longint unsigned w, lvl, d, len, fade;
    longint unsigned ch [3];
    rgb_t res;
    w   = wl;
    lvl = (inten > ONE_Q) ? ONE_Q : inten;
    ch  = '{0, 0, 0};
    if (w < W_380) begin
      // below the band: fixed dim violet, no edge fade
      ch[0] = DIM_Q;
      ch[2] = DIM_Q;
    end else if (w > W_750) begin
      // above the band: fixed dim red
      ch[0] = DIM_Q;
    end else begin
      if (w < W_440) begin
        d = w - W_380; len = W_440 - W_380;
        ch[0] = div_round(16384 * (len - d), len);
        ch[2] = ONE_Q;
      end else if (w < W_490) begin
        d = w - W_440; len = W_490 - W_440;
        ch[1] = div_round(32768 * d, len);
        ch[2] = ONE_Q;
      end else if (w < W_510) begin
        d = w - W_490; len = W_510 - W_490;
        ch[1] = ONE_Q;
        ch[2] = div_round(32768 * (len - d), len);
      end else if (w < W_580) begin
        d = w - W_510; len = W_580 - W_510;
        ch[0] = div_round(32768 * d, len);
        ch[1] = ONE_Q;
      end else if (w < W_645) begin
        d = w - W_580; len = W_645 - W_580;
        ch[0] = ONE_Q;
        ch[1] = div_round(16384 * (2 * len - d), len);
      end else begin
        d = w - W_645; len = W_750 - W_645;
        ch[0] = ONE_Q;
        ch[1] = div_round(16384 * (len - d), len);
      end
      // edge fade down to 0.3 at either end of the band
      if (w < W_420)
        fade = div_round(32768 * (7680 + 7 * (w - W_380)), 25600);
      else if (w > W_700)
        fade = div_round(32768 * (9600 + 7 * (W_750 - w)), 32000);
      else
        fade = ONE_Q;
      foreach (ch[k])
        ch[k] = uq_mul((ch[k] > ONE_Q) ? ONE_Q : ch[k], fade);
    end
    res.red   = 16'(uq_mul(ch[0], lvl));
    res.green = 16'(uq_mul(ch[1], lvl));
    res.blue  = 16'(uq_mul(ch[2], lvl));
    return res;
  endfunction

  // Mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap(bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 60)
      return 0;
    else if (r < 92)
      return $urandom_range(1, 3);
    else
      return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: offers one word, waits for the handshake, queues its colour.
  // tvalid stays high into the next word when no gap follows.
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic [15:0] wl, input logic [15:0] inten);
    int gap;
    s_tdata  <= {inten, wl};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    colour_due = {colour_due, predict_colour(wl, inten)};
    words_sent++;
    gap = pick_gap(send_idle);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop tvalid and let every predicted colour come back
  task automatic drain_colours();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (colour_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_wavelength();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65)
      return 16'($urandom_range(W_380, W_750));
    else if (r < 85)
      return 16'(BORDERS[$urandom_range(0, 8)] + $urandom_range(0, 6) - 3);
    else
      return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [15:0] pick_intensity();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40)
      return 16'($urandom_range(0, ONE_Q));
    else if (r < 60)
      return ONE_Q;
    else if (r < 68)
      return 16'd0;
    else
      return 16'($urandom_range(0, 65535));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Band ends, every segment border, both fade edges, out-of-band colours and
  // the intensity corners (zero, just under, at and over 1.0, all ones).
  task automatic test_band_edges();
    logic [15:0] wl_list  [22] = '{16'd0, 16'd24319, W_380, 16'd24321, 16'd26879,
                                   W_420, W_440, W_490, W_510, W_580, W_645,
                                   W_700, 16'd44801, 16'd47999, W_750, 16'd48001,
                                   16'hFFFF, 16'd33000, 16'd33000, 16'd33000,
                                   16'd29000, 16'd46000};
    logic [15:0] int_list [22] = '{16'hFFFF, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q,
                                   ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q,
                                   ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, 16'd0,
                                   16'd32767, 16'd32769, 16'hFFFF, 16'd1};
    send_idle = 1'b1;
    recv_idle = 1'b1;
    foreach (wl_list[k])
      send_word(wl_list[k], int_list[k]);
    drain_colours();
  endtask

  // Random spectrum; idling on either side is re-picked at random every 50 words
  task automatic test_random_spectrum();
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 50 == 0) begin
        send_idle = ($urandom_range(0, 2) != 0);
        recv_idle = ($urandom_range(0, 2) != 0);
      end
      send_word(pick_wavelength(), pick_intensity());
    end
    drain_colours();
  endtask

  // Receiver holds off for a long stretch while words keep coming, so the
  // queue fills and the input stalls
  task automatic test_output_stall();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    hold_req  = 1'b1;
    for (int n = 0; n < BURST_WORDS; n++)
      send_word(pick_wavelength(), pick_intensity());
    drain_colours();
  endtask

  // Back-to-back words, output always ready: one word per cycle expected
  task automatic test_full_rate();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    for (int n = 0; n < STREAM_WORDS; n++)
      send_word(pick_wavelength(), pick_intensity());
    drain_colours();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int stall_left;
    m_tready   = 1'b0;
    stall_left = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        long_holds++;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
        @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        stall_left = pick_gap(recv_idle);
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output check: each word against the oldest predicted colour
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rgb_t want;
    rgb_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (colour_due.size() == 0) begin
        $display("%0t: unexpected colour word %h", $time, m_tdata);
        mismatches++;
      end else begin
        want = colour_due.pop_front();
        colours_checked++;
        if (got.red !== want.red) begin
          $display("%0t: red expected %0d got %0d", $time, want.red, got.red);
          mismatches++;
        end
        if (got.green !== want.green) begin
          $display("%0t: green expected %0d got %0d", $time, want.green, got.green);
          mismatches++;
        end
        if (got.blue !== want.blue) begin
          $display("%0t: blue expected %0d got %0d", $time, want.blue, got.blue);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: ends the run if no word moves on either side for too long
  initial begin
    int quiet;
    quiet = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
    $display("testbench failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst             = 1'b1;
    s_tvalid        = 1'b0;
    s_tdata         = '0;
    send_idle       = 1'b0;
    recv_idle       = 1'b0;
    hold_req        = 1'b0;
    words_sent      = 0;
    colours_checked = 0;
    mismatches      = 0;
    long_holds      = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_band_edges();
    test_random_spectrum();
    test_output_stall();
    test_full_rate();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d wavelength words, checked %0d colours, %0d field mismatches.",
             words_sent, colours_checked, mismatches);
    $display("Covered borders, fades, out-of-band, intensity corners, %0d long hold(s).",
             long_holds);
    if (mismatches == 0 && colour_due.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("%0d colour(s) still outstanding", colour_due.size());
      $display("testbench failed");
    end
    $finish;
  end

endmodule
